// ----- design/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;
    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;
    localparam int TAG_BITS = 16;
    localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS = KEY_BITS + TAG_BITS;

    typedef logic [2:0] t_action;
    localparam t_action ACT_OFFER = 3'd0;
    localparam t_action ACT_PEEK = 3'd1;
    localparam t_action ACT_POLL = 3'd2;
    localparam t_action ACT_AT = 3'd3;
    localparam t_action ACT_REMOVE = 3'd4;
    localparam t_action ACT_REMOVE_AT = 3'd5;
    localparam t_action ACT_SIZE = 3'd6;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL = 2'd2;
    localparam t_status ST_NULL = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_COMPACT,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ----- design/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in one RAM; at most one walk of the table per op.
// ----------------------------------------------------------------------------
// Size, rejected and unused ops go straight to the result state; peek and at
// read one word; poll, remove by tag and remove at walk from the index to the
// end of the table; offer scans for its slot, then shifts the later entries up.
// busy drops in the cycle after the result strobe.
// Reset clears the count and the order bit; table contents need no clearing.
// The receiver cannot stall: o_valid lasts one cycle.
module sorted_priority_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_data,
    input  wire logic [2:0]                    i_action,
    input  wire logic [15:0]                   i_entry_key,
    input  wire logic [15:0]                   i_entry_tag,
    input  wire logic [3:0]                    i_position,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic [4:0]                         o_count_or_place,
    output logic [15:0]                        o_out_key,
    output logic [15:0]                        o_out_tag
);
    import spq_pkg::*;

    t_state r_state, n_state;
    logic   r_desc;
    logic [CNT_BITS-1:0]   r_count, n_count;
    t_action               r_act;
    logic [KEY_BITS-1:0]   r_key;
    logic [TAG_BITS-1:0]   r_tag;
    // read pointer (index of word arriving next cycle), write pointer
    logic [CNT_BITS-1:0]   r_rd, n_rd, r_wr, n_wr;
    logic                  r_rvalid, n_rvalid;   // RAM data valid this cycle
    logic [CNT_BITS-1:0]   r_rdi, n_rdi;         // index of word on rdata
    logic [ENTRY_BITS-1:0] r_carry, n_carry;     // entry displaced by insertion
    logic                  r_placed, n_placed;
    logic [1:0]            r_st, n_st;
    logic [4:0]            r_cnt, n_cnt;
    logic [KEY_BITS-1:0]   r_okey, n_okey;
    logic [TAG_BITS-1:0]   r_otag, n_otag;

    logic                  we;
    logic [ADDR_BITS-1:0]  waddr, raddr;
    logic [ENTRY_BITS-1:0] wdata, rdata;
    logic [KEY_BITS-1:0]   rkey;
    logic [TAG_BITS-1:0]   rtag;
    logic                  accept, served_first;
    logic [CNT_BITS-1:0]   pos_ext;

    spq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rkey         = rdata[ENTRY_BITS-1:TAG_BITS];
    assign rtag         = rdata[TAG_BITS-1:0];
    assign accept       = start && !busy;
    assign served_first = r_desc ? (r_key > rkey) : (r_key < rkey);
    assign pos_ext      = CNT_BITS'(i_position);
    assign busy         = (r_state != S_IDLE);
    // issue the read of the word that must sit on rdata next cycle
    assign raddr        = n_rdi[ADDR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_desc   <= 1'b0;
            r_count  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rvalid <= n_rvalid;
            if (i_cfg_we) begin
                r_desc <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action;
            r_key <= KEY_BITS'(i_entry_key);
            r_tag <= TAG_BITS'(i_entry_tag);
        end
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_rdi    <= n_rdi;
        r_carry  <= n_carry;
        r_placed <= n_placed;
        r_st     <= n_st;
        r_cnt    <= n_cnt;
        r_okey   <= n_okey;
        r_otag   <= n_otag;
    end

    // Next state, counters and RAM access
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_rdi    = r_rd;
        n_rvalid = 1'b0;
        n_carry  = r_carry;
        n_placed = r_placed;
        n_st     = r_st;
        n_cnt    = r_cnt;
        n_okey   = r_okey;
        n_otag   = r_otag;
        we       = 1'b0;
        waddr    = r_wr[ADDR_BITS-1:0];
        wdata    = rdata;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_st     = ST_OK;
                    n_cnt    = '0;
                    n_okey   = '0;
                    n_otag   = '0;
                    n_wr     = '0;
                    n_placed = 1'b0;
                    n_state  = S_DONE;
                    n_rd     = '0;
                    case (i_action)
                        ACT_OFFER: begin
                            if (TAG_BITS'(i_entry_tag) == '0) begin
                                n_st = ST_NULL;
                            end else if (r_count >= CNT_BITS'(CAPACITY)) begin
                                n_st = ST_FULL;
                            end else begin
                                n_rvalid = (r_count != '0);
                                n_state  = S_SCAN;
                            end
                        end
                        ACT_PEEK, ACT_POLL: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_rvalid = 1'b1;
                                n_state  = S_COMPACT;
                            end
                        end
                        ACT_AT, ACT_REMOVE_AT: begin
                            if (pos_ext >= r_count) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_rvalid = 1'b1;
                                n_rd     = pos_ext;
                                n_wr     = pos_ext;
                                n_state  = S_COMPACT;
                            end
                        end
                        ACT_REMOVE: begin
                            n_rvalid = (r_count != '0);
                            n_state  = (r_count != '0) ? S_COMPACT : S_DONE;
                        end
                        ACT_SIZE: n_cnt = 5'(r_count);
                        default: ;
                    endcase
                    n_rdi = n_rd;
                    n_rd  = n_rd + 1'b1;
                end
            end
            S_SCAN: begin
                // Offer: find slot, then shift later entries up by one
                if (r_rvalid && !served_first) begin
                    n_rvalid = (r_rd < r_count);
                    n_rd     = r_rd + 1'b1;
                end else begin
                    n_cnt    = 5'(r_rdi);
                    n_wr     = r_rdi;
                    n_state  = S_SHIFT;
                    n_carry  = {r_key, r_tag};
                    n_rvalid = r_rvalid;
                    n_rd     = r_rd;
                    n_rdi    = r_rdi;
                    if (!r_rvalid) begin
                        n_rdi = r_count;
                    end
                    n_cnt = 5'(n_rdi);
                    n_wr  = n_rdi;
                end
            end
            S_SHIFT: begin
                // write carried entry at r_wr; rdata holds old entry r_wr
                we    = 1'b1;
                wdata = r_carry;
                n_wr  = r_wr + 1'b1;
                if (r_wr == r_count) begin
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_carry  = rdata;
                    n_rvalid = (r_rd < r_count);
                    n_rd     = r_rd + 1'b1;
                end
            end
            S_COMPACT: begin
                if (r_rvalid) begin
                    n_rvalid = (r_rd < r_count);
                    n_rd     = r_rd + 1'b1;
                    if (r_act == ACT_REMOVE) begin
                        if (r_tag != '0 && rtag == r_tag) begin
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            we   = 1'b1;
                            n_wr = r_wr + 1'b1;
                        end
                    end else if (!r_placed) begin
                        // first word is the returned entry
                        n_okey   = rkey;
                        n_otag   = rtag;
                        n_placed = 1'b1;
                        if (r_act == ACT_PEEK || r_act == ACT_AT) begin
                            n_state = S_DONE;
                        end
                    end else begin
                        we   = 1'b1;
                        n_wr = r_wr + 1'b1;
                    end
                end else begin
                    if (r_act == ACT_REMOVE) begin
                        n_count = r_wr;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_valid          = (r_state == S_DONE);
        o_status         = r_st;
        o_count_or_place = r_cnt;
        o_out_key        = 16'(r_okey);
        o_out_tag        = 16'(r_otag);
    end

    // Assertions
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("entry count beyond capacity");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted op did not raise busy");
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL || o_status == ST_NULL)) |->
        $stable(r_count))
        else $error("rejected offer changed the count");
endmodule
`default_nettype wire

// ----- design/spq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- tb/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches the command and result beats of the sorted priority queue, keeps
// its own sorted table to predict each result, and counts mismatches.
// ----------------------------------------------------------------------------
module spq_checker
    import spq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    input  wire logic [2:0]  i_action,
    input  wire logic [15:0] i_entry_key,
    input  wire logic [15:0] i_entry_tag,
    input  wire logic [3:0]  i_position,
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_status,
    input  wire logic [4:0]  i_count_or_place,
    input  wire logic [15:0] i_out_key,
    input  wire logic [15:0] i_out_tag,
    output int               o_errors,
    output int               o_pending,
    output int               o_beats
);
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  cnt;
        logic [15:0] okey;
        logic [15:0] otag;
    } t_reply;

    logic [15:0] q_key [CAPACITY];
    logic [15:0] q_tag [CAPACITY];
    int          q_fill;
    logic        descending;
    t_reply      replies_due [$];

    function automatic logic ahead(logic [15:0] a, logic [15:0] b);
        return descending ? (a > b) : (a < b);
    endfunction

    task automatic drop_entry(int idx);
        for (int i = idx; i + 1 < q_fill; i++) begin
            q_key[i] = q_key[i + 1];
            q_tag[i] = q_tag[i + 1];
        end
        q_fill--;
    endtask

    task automatic queue_op(t_action act, logic [15:0] key, logic [15:0] tag,
                            logic [3:0] pos);
        t_reply r;
        int     i;
        int     j;
        r = '0;
        case (act)
            ACT_OFFER: begin
                if (tag == 0) r.status = ST_NULL;
                else if (q_fill >= CAPACITY) r.status = ST_FULL;
                else begin
                    i = 0;
                    while (i < q_fill && !ahead(key, q_key[i])) i++;
                    for (j = q_fill; j > i; j--) begin
                        q_key[j] = q_key[j - 1];
                        q_tag[j] = q_tag[j - 1];
                    end
                    q_key[i] = key;
                    q_tag[i] = tag;
                    q_fill++;
                    r.cnt = 5'(i);
                end
            end
            ACT_PEEK, ACT_POLL: begin
                if (q_fill == 0) r.status = ST_EMPTY;
                else begin
                    r.okey = q_key[0];
                    r.otag = q_tag[0];
                    if (act == ACT_POLL) drop_entry(0);
                end
            end
            ACT_AT, ACT_REMOVE_AT: begin
                if (pos >= q_fill) r.status = ST_EMPTY;
                else begin
                    r.okey = q_key[pos];
                    r.otag = q_tag[pos];
                    if (act == ACT_REMOVE_AT) drop_entry(pos);
                end
            end
            ACT_REMOVE: begin
                j = 0;
                for (i = 0; i < q_fill; i++) begin
                    if (tag != 0 && q_tag[i] == tag) r.cnt++;
                    else begin
                        q_key[j] = q_key[i];
                        q_tag[j] = q_tag[i];
                        j++;
                    end
                end
                q_fill = j;
            end
            ACT_SIZE: r.cnt = 5'(q_fill);
            default: ;
        endcase
        replies_due.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_reply e;
        if (!i_rst_n) begin
            q_fill = 0;
            descending = 1'b0;
            replies_due.delete();
            o_errors <= 0;
            o_beats <= 0;
        end else begin
            if (i_cfg_we) descending = i_cfg_data;
            if (i_start && !i_busy)
                queue_op(t_action'(i_action), i_entry_key, i_entry_tag, i_position);
            if (i_valid) begin
                o_beats <= o_beats + 1;
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result beat st=%0d cnt=%0d key=%h tag=%h",
                             $time, i_status, i_count_or_place, i_out_key, i_out_tag);
                    o_errors <= o_errors + 1;
                end else begin
                    e = replies_due.pop_front();
                    if (e.status !== i_status || e.cnt !== i_count_or_place
                        || e.okey !== i_out_key || e.otag !== i_out_tag) begin
                        $display("%0t: mismatch exp st=%0d cnt=%0d key=%h tag=%h",
                                 $time, e.status, e.cnt, e.okey, e.otag);
                        $display("%0t:          act st=%0d cnt=%0d key=%h tag=%h",
                                 $time, i_status, i_count_or_place, i_out_key,
                                 i_out_tag);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= replies_due.size();
    end
endmodule

// ----- tb/sorted_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Drives directed and random queue commands in bursts, flips the order bit
// between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int WATCHDOG = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic [2:0]  i_action = '0;
    logic [15:0] i_entry_key = '0;
    logic [15:0] i_entry_tag = '0;
    logic [3:0]  i_position = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [4:0]  o_count_or_place;
    logic [15:0] o_out_key;
    logic [15:0] o_out_tag;
    int          errors;
    int          pending;
    int          beats;
    int          idle_cycles = 0;
    int          live_tags [$];

    always #5 i_clk = ~i_clk;

    sorted_priority_queue dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_we, .i_cfg_data,
        .i_action, .i_entry_key, .i_entry_tag, .i_position,
        .o_valid, .o_status, .o_count_or_place, .o_out_key, .o_out_tag
    );

    spq_checker chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cfg_we, .i_cfg_data,
        .i_action, .i_entry_key, .i_entry_tag, .i_position,
        .i_valid(o_valid), .i_status(o_status), .i_count_or_place(o_count_or_place),
        .i_out_key(o_out_key), .i_out_tag(o_out_tag),
        .o_errors(errors), .o_pending(pending), .o_beats(beats)
    );

    // watchdog: cycles with no command or result beat
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL sorted_priority_queue");
            $finish;
        end
    end

    task automatic send_cmd(t_action act, logic [15:0] key, logic [15:0] tag,
                            logic [3:0] pos);
        @(posedge i_clk);
        start <= 1'b1;
        i_action <= act;
        i_entry_key <= key;
        i_entry_tag <= tag;
        i_position <= pos;
        do @(posedge i_clk); while (busy);
        start <= 1'b0;
        if (act == ACT_OFFER && tag != 0) live_tags.push_back(tag);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
    endtask

    task automatic set_order(logic desc);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= desc;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_cmd(int bias);
        int          pick;
        t_action     act;
        logic [15:0] key;
        logic [15:0] tag;
        pick = $urandom_range(99);
        // offers dominate in the first two phases so the table fills and the full case is reached
        if (pick < bias) act = ACT_OFFER;
        else act = t_action'($urandom_range(7));
        key = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
        tag = 16'($urandom);
        if ($urandom_range(15) == 0) tag = 0;
        if (act == ACT_REMOVE && live_tags.size() != 0 && $urandom_range(1))
            tag = live_tags[$urandom_range(live_tags.size() - 1)];
        else if (act == ACT_OFFER && live_tags.size() != 0 && $urandom_range(4) == 0)
            tag = live_tags[$urandom_range(live_tags.size() - 1)];
        send_cmd(act, key, tag, 4'($urandom));
    endtask

    initial begin
        int sent;
        int burst;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty cases, null tag, fill to full, extremes, each action
        send_cmd(ACT_PEEK, 0, 0, 0);
        send_cmd(ACT_POLL, 0, 0, 0);
        send_cmd(ACT_AT, 0, 0, 0);
        send_cmd(ACT_REMOVE_AT, 0, 0, 0);
        send_cmd(ACT_REMOVE, 0, 0, 0);
        send_cmd(ACT_OFFER, 16'h1234, 16'h0000, 0);
        send_cmd(3'd7, 16'hffff, 16'hffff, 4'hf);
        for (int i = 0; i < CAPACITY; i++)
            send_cmd(ACT_OFFER, (i % 3 == 0) ? 16'hffff : 16'(i & 1), 16'(i + 1), 0);
        send_cmd(ACT_OFFER, 16'h0000, 16'hffff, 0);
        send_cmd(ACT_SIZE, 0, 0, 0);
        send_cmd(ACT_AT, 0, 0, 4'hf);
        send_cmd(ACT_REMOVE_AT, 0, 0, 4'hf);
        send_cmd(ACT_AT, 0, 0, 4'hf);
        send_cmd(ACT_REMOVE, 0, 16'h0000, 0);
        send_cmd(ACT_REMOVE, 0, 16'h0002, 0);
        send_cmd(ACT_PEEK, 0, 0, 0);
        send_cmd(ACT_POLL, 0, 0, 0);

        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            set_order(phase[0] ? 1'b1 : 1'b0);
            live_tags.delete();
            while (sent < (phase + 1) * 150) begin
                burst = $urandom_range(1, 12);
                repeat (burst) begin
                    random_cmd(phase < 2 ? 55 : 35);
                    sent++;
                end
                if (sent % 100 < 12) begin
                    while (pending != 0) @(posedge i_clk);
                end else if ($urandom_range(2) != 0) begin
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("PASS sorted_priority_queue");
        end else begin
            $display("FAIL sorted_priority_queue");
        end
        $finish;
    end
endmodule
